>>> rtl/tc_pkg.sv
// ----------------------------------------------------------------------------
// tc_pkg
// Shared types and constants of the Tamura contrast block.
// ----------------------------------------------------------------------------
package tc_pkg;

   localparam int GREY_LEVELS = 256;
   localparam int GREY_W      = 8;
   localparam int CON_W       = 15;
   localparam int ROOT_W      = 24;
   localparam int QUO_W       = 64;

   typedef struct packed {
      logic [GREY_W-1:0] pixel;
      logic              last;
   } req_type;

   typedef struct packed {
      logic [CON_W-1:0] contrast;
      logic             degenerate;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_WRITE,
      ST_PASS1,
      ST_WAIT_P1,
      ST_MEAN,
      ST_WAIT_MEAN,
      ST_PASS2,
      ST_WAIT_P2,
      ST_VAR,
      ST_WAIT_VAR,
      ST_U4,
      ST_WAIT_U4,
      ST_SQ1,
      ST_WAIT_SQ1,
      ST_SQ2,
      ST_WAIT_SQ2,
      ST_CON,
      ST_WAIT_CON,
      ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_WRITE,
      CMD_PASS1,
      CMD_PASS2,
      CMD_DIV_MEAN,
      CMD_DIV_VAR,
      CMD_DIV_U4,
      CMD_SQRT_U4,
      CMD_SQRT_S,
      CMD_DIV_CON,
      CMD_OUTPUT
   } op_type;

   typedef enum logic [2:0] {
      DST_MEAN,
      DST_VAR,
      DST_U4,
      DST_S,
      DST_ROOT,
      DST_CON
   } dest_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic degen;
   } status_type;

endpackage

>>> rtl/tc_div.sv
// ----------------------------------------------------------------------------
// tc_div
// Restoring divider, one quotient bit per cycle over the whole numerator.
// ----------------------------------------------------------------------------
module tc_div
   import tc_pkg::*;
#(
   parameter int NUM_W = 85,
   parameter int DEN_W = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic             done,
   output logic [QUO_W-1:0] quo
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [QUO_W-1:0] quo_ff;
   logic [QUO_W-1:0] quo_in;
   logic [DEN_W:0]   rem_shift;
   logic             fits;
   logic [DEN_W-1:0] rem_in;

   assign rem_shift = {rem_ff, num_ff[NUM_W-1]};
   assign fits      = rem_shift >= {1'b0, den_ff};
   assign rem_in    = fits ? DEN_W'(rem_shift - {1'b0, den_ff}) : rem_shift[DEN_W-1:0];
   assign quo_in    = {quo_ff[QUO_W-2:0], fits};
   assign done      = busy_ff && (cnt_ff == CNT_W'(NUM_W - 1));
   assign busy      = busy_ff;
   // The quotient is taken in the cycle that done is high, last bit included.
   assign quo       = quo_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (done) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         den_ff <= den;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[NUM_W-2:0], 1'b0};
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

endmodule

>>> rtl/tc_sqrt.sv
// ----------------------------------------------------------------------------
// tc_sqrt
// Bit-pair integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module tc_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] x,
   output logic        busy,
   output logic        done,
   output logic [31:0] root
);

   logic        busy_ff;
   logic [4:0]  cnt_ff;
   logic [63:0] x_ff;
   logic [63:0] res_ff;
   logic [63:0] res_in;
   logic [63:0] bit_ff;
   logic [64:0] trial;
   logic        take;

   assign trial  = {1'b0, res_ff} + {1'b0, bit_ff};
   assign take   = {1'b0, x_ff} >= trial;
   assign res_in = take ? (res_ff >> 1) + bit_ff : res_ff >> 1;
   assign done   = busy_ff && (cnt_ff == 5'd31);
   assign busy   = busy_ff;
   // The root is taken in the cycle that done is high, last step included.
   assign root   = res_in[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (done) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff   <= x;
         res_ff <= '0;
         bit_ff <= 64'h4000_0000_0000_0000;
      end else if (busy_ff) begin
         if (take) begin
            x_ff <= x_ff - trial[63:0];
         end
         res_ff <= res_in;
         bit_ff <= bit_ff >> 2;
      end
   end

endmodule

>>> rtl/tc_datapath.sv
// ----------------------------------------------------------------------------
// tc_datapath
// Histogram memory, moment accumulation passes, shared divider and square root.
// ----------------------------------------------------------------------------
module tc_datapath
   import tc_pkg::*;
#(
   parameter int MAX_PIXELS = 1048576
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  req_type    req_data,
   output status_type status,
   output rsp_type    rsp_data
);

   localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
   localparam int S1_W   = CNT_W + GREY_W;
   localparam int MN_W   = CNT_W + 17;
   localparam int V_W    = CNT_W + 32;
   localparam int T_W    = CNT_W + 64;
   localparam int DEN_W  = (CNT_W > ROOT_W) ? CNT_W : ROOT_W;

   // Histogram store; bins not marked valid read as zero.
   logic [CNT_W-1:0]       hist_mem [GREY_LEVELS];
   logic [GREY_LEVELS-1:0] valid_ff;
   logic [CNT_W-1:0]       rd_ff;
   logic                   rdv_ff;
   logic [GREY_W-1:0]      rd_addr;
   logic [CNT_W-1:0]       h;

   logic [CNT_W-1:0]  count_ff;
   logic [GREY_W-1:0] pix_ff;
   logic              ok_ff;

   logic              pass_ff;
   logic              second_ff;
   logic [2:0]        sub_ff;
   logic [GREY_W-1:0] bin_ff;
   logic              bin_end;

   logic [S1_W-1:0]  s1_ff;
   logic [V_W-1:0]   v_ff;
   logic [T_W-1:0]   t_ff;
   logic [CNT_W-1:0] h_ff;
   logic [15:0]      d_ff;
   logic [31:0]      d2_ff;
   logic [63:0]      d4_ff;
   logic [15:0]      pos;

   logic [S1_W-1:0]      p_hg;
   logic [V_W-1:0]       p_hd2;
   logic [CNT_W+31:0]    p_hd4;

   logic [15:0]       mean_ff;
   logic [31:0]       var_ff;
   logic [63:0]       u4_ff;
   logic [31:0]       s_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [CON_W-1:0]  con_ff;
   dest_type          dest_ff;
   rsp_type           rsp_ff;

   logic             div_start;
   logic [T_W-1:0]   div_num;
   logic [DEN_W-1:0] div_den;
   logic             div_busy;
   logic             div_done;
   logic [QUO_W-1:0] div_quo;
   logic [MN_W-1:0]  mean_num;

   logic        sq_start;
   logic [63:0] sq_x;
   logic        sq_busy;
   logic        sq_done;
   logic [31:0] sq_root;

   assign rd_addr = (cmd.op == CMD_LOAD) ? req_data.pixel : bin_ff;
   assign h       = rdv_ff ? rd_ff : '0;

   always_ff @(posedge clock) begin
      rd_ff  <= hist_mem[rd_addr];
      rdv_ff <= valid_ff[rd_addr];
      if (cmd.op == CMD_WRITE && ok_ff) begin
         hist_mem[pix_ff] <= h + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         ok_ff    <= 1'b0;
      end else begin
         case (cmd.op)
            CMD_LOAD: begin
               ok_ff <= count_ff < CNT_W'(MAX_PIXELS);
               if (count_ff < CNT_W'(MAX_PIXELS)) begin
                  count_ff <= count_ff + 1'b1;
               end
            end
            CMD_WRITE: begin
               if (ok_ff) begin
                  valid_ff[pix_ff] <= 1'b1;
               end
            end
            CMD_OUTPUT: begin
               valid_ff <= '0;
               count_ff <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == CMD_LOAD) begin
         pix_ff <= req_data.pixel;
      end
   end

   // Bin sweep: sub_ff steps through each bin, for the mean pass and for the moment pass.
   assign bin_end = bin_ff == GREY_W'(GREY_LEVELS - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff   <= 1'b0;
         second_ff <= 1'b0;
         sub_ff    <= '0;
         bin_ff    <= '0;
      end else if (cmd.op == CMD_PASS1 || cmd.op == CMD_PASS2) begin
         pass_ff   <= 1'b1;
         second_ff <= cmd.op == CMD_PASS2;
         sub_ff    <= '0;
         bin_ff    <= '0;
      end else if (pass_ff) begin
         if ((!second_ff && sub_ff == 3'd1) || (second_ff && sub_ff == 3'd5)) begin
            sub_ff <= '0;
            bin_ff <= bin_ff + 1'b1;
            if (bin_end) begin
               pass_ff <= 1'b0;
            end
         end else begin
            sub_ff <= sub_ff + 1'b1;
         end
      end
   end

   assign pos   = {bin_ff, 8'h00};
   assign p_hg  = h * bin_ff;
   assign p_hd2 = h_ff * d2_ff;
   assign p_hd4 = (sub_ff == 3'd4) ? h_ff * d4_ff[31:0] : h_ff * d4_ff[63:32];

   always_ff @(posedge clock) begin
      if (cmd.op == CMD_PASS1 || cmd.op == CMD_PASS2) begin
         s1_ff <= (cmd.op == CMD_PASS1) ? '0 : s1_ff;
         v_ff  <= '0;
         t_ff  <= '0;
      end else if (pass_ff) begin
         if (!second_ff) begin
            if (sub_ff == 3'd1) begin
               s1_ff <= s1_ff + p_hg;
            end
         end else begin
            case (sub_ff)
               3'd1: begin
                  h_ff <= h;
                  d_ff <= (pos >= mean_ff) ? pos - mean_ff : mean_ff - pos;
               end
               3'd2: d2_ff <= d_ff * d_ff;
               3'd3: begin
                  d4_ff <= d2_ff * d2_ff;
                  v_ff  <= v_ff + p_hd2;
               end
               3'd4: t_ff <= t_ff + T_W'(p_hd4);
               3'd5: t_ff <= t_ff + (T_W'(p_hd4) << 32);
               default: begin
               end
            endcase
         end
      end
   end

   // Shared divider and square root; the result lands in the register named
   // by dest_ff when the unit finishes.
   assign mean_num = MN_W'({s1_ff, 8'h00}) + MN_W'(count_ff >> 1);

   always_comb begin
      div_start = 1'b1;
      div_num   = T_W'(mean_num);
      div_den   = DEN_W'(count_ff);
      case (cmd.op)
         CMD_DIV_MEAN: begin
         end
         CMD_DIV_VAR: div_num = T_W'(v_ff);
         CMD_DIV_U4:  div_num = t_ff;
         CMD_DIV_CON: begin
            div_num = T_W'({var_ff, 8'h00});
            div_den = DEN_W'(root_ff);
         end
         default: div_start = 1'b0;
      endcase
   end

   assign sq_start = (cmd.op == CMD_SQRT_U4) || (cmd.op == CMD_SQRT_S);
   assign sq_x     = (cmd.op == CMD_SQRT_U4) ? u4_ff : {16'h0000, s_ff, 16'h0000};

   tc_div #(
      .NUM_W (T_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quo   (div_quo)
   );

   tc_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .x     (sq_x),
      .busy  (sq_busy),
      .done  (sq_done),
      .root  (sq_root)
   );

   always_ff @(posedge clock) begin
      case (cmd.op)
         CMD_DIV_MEAN: dest_ff <= DST_MEAN;
         CMD_DIV_VAR:  dest_ff <= DST_VAR;
         CMD_DIV_U4:   dest_ff <= DST_U4;
         CMD_SQRT_U4:  dest_ff <= DST_S;
         CMD_SQRT_S:   dest_ff <= DST_ROOT;
         CMD_DIV_CON:  dest_ff <= DST_CON;
         default: begin
         end
      endcase
      if (div_done || sq_done) begin
         unique case (dest_ff)
            DST_MEAN: mean_ff <= div_quo[15:0];
            DST_VAR:  var_ff  <= div_quo[31:0];
            DST_U4:   u4_ff   <= div_quo;
            DST_S:    s_ff    <= sq_root;
            DST_ROOT: root_ff <= sq_root[ROOT_W-1:0];
            DST_CON:  con_ff  <= (|div_quo[QUO_W-1:CON_W]) ? {CON_W{1'b1}}
                                                            : div_quo[CON_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign status.busy  = pass_ff || div_busy || sq_busy;
   assign status.degen = (var_ff == '0) || (root_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.op == CMD_OUTPUT) begin
         rsp_ff.contrast   <= status.degen ? '0 : con_ff;
         rsp_ff.degenerate <= status.degen;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

>>> rtl/tc_ctrl.sv
// ----------------------------------------------------------------------------
// tc_ctrl
// Sequencer: pixel transfers, end-of-frame moment steps and the result slot.
// ----------------------------------------------------------------------------
module tc_ctrl
   import tc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      last_ff, last_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.op       = CMD_NONE;
      req_stall    = state_ff != ST_IDLE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = CMD_LOAD;
               last_in  = req_last;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.op   = CMD_WRITE;
            state_in = last_ff ? ST_PASS1 : ST_IDLE;
         end
         ST_PASS1: begin
            cmd.op   = CMD_PASS1;
            state_in = ST_WAIT_P1;
         end
         ST_WAIT_P1:   if (!status.busy) state_in = ST_MEAN;
         ST_MEAN: begin
            cmd.op   = CMD_DIV_MEAN;
            state_in = ST_WAIT_MEAN;
         end
         ST_WAIT_MEAN: if (!status.busy) state_in = ST_PASS2;
         ST_PASS2: begin
            cmd.op   = CMD_PASS2;
            state_in = ST_WAIT_P2;
         end
         ST_WAIT_P2:   if (!status.busy) state_in = ST_VAR;
         ST_VAR: begin
            cmd.op   = CMD_DIV_VAR;
            state_in = ST_WAIT_VAR;
         end
         ST_WAIT_VAR:  if (!status.busy) state_in = ST_U4;
         ST_U4: begin
            cmd.op   = CMD_DIV_U4;
            state_in = ST_WAIT_U4;
         end
         ST_WAIT_U4:   if (!status.busy) state_in = ST_SQ1;
         ST_SQ1: begin
            cmd.op   = CMD_SQRT_U4;
            state_in = ST_WAIT_SQ1;
         end
         ST_WAIT_SQ1:  if (!status.busy) state_in = ST_SQ2;
         ST_SQ2: begin
            cmd.op   = CMD_SQRT_S;
            state_in = ST_WAIT_SQ2;
         end
         ST_WAIT_SQ2:  if (!status.busy) state_in = ST_CON;
         ST_CON: begin
            // A zero variance or root skips the final division.
            if (status.degen) begin
               state_in = ST_OUT;
            end else begin
               cmd.op   = CMD_DIV_CON;
               state_in = ST_WAIT_CON;
            end
         end
         ST_WAIT_CON:  if (!status.busy) state_in = ST_OUT;
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.op       = CMD_OUTPUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/tamura_contrast.sv
// A pixel without last passes the load and write steps; a frame's last pixel then runs
// the mean sweep, the moment sweep, three divider runs, two square-root runs and,
// unless the result is degenerate, a final division, then the output step.
// req_stall holds each new pixel until the histogram read-modify-write is done.
// Reset clears the histogram valid bits, the pixel count and the sequencer, sweep and unit busy state.
// ----------------------------------------------------------------------------
// tamura_contrast
// Grey-level histogram and Tamura contrast per frame, unsigned Q7.8 result.
// ----------------------------------------------------------------------------
module tamura_contrast
   import tc_pkg::*;
#(
   parameter int MAX_PIXELS = 1048576
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   tc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tc_datapath #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
